@@ design/dtw_pkg.sv @@
package dtw_pkg;

  localparam int DIST_W    = 16;
  localparam int COST_W    = 32;
  localparam int LEN_W     = 12;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [COST_W-1:0] COST_INF  = '1;
  localparam logic [COST_W-1:0] COST_ZERO = '0;
  localparam logic [LEN_W-1:0]  LEN_MAX   = '1;
  localparam logic [LEN_W-1:0]  LEN_ONE   = LEN_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);

  // one quotient bit per divide step
  localparam int DIV_STEPS = COST_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic accept;    // latch distance, read row store
    logic update;    // evaluate cell, write row store
    logic div_step;  // one restoring divide step
  } dtw_cmd_t;

  typedef struct packed {
    logic matrix_done;  // current cell is the last of the matrix
    logic div_last;     // divider is at its final step
  } dtw_sts_t;

endpackage

@@ design/dtw_length_normalized_score_core.sv @@
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   distance_i
// out      output     out_valid_o / out_ready_i score_o, cost_saturated_o
// cfg      input      cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// each distance is a row store read, then the cell update and write-back, before the next is taken
// the last cell of a matrix adds the restoring divide of cost by length
// the score sits in an output register, so the next matrix streams in while it waits
// the final divide step stalls only if the previous score has not been taken yet
// reset restores 1x1 dimensions; the row store needs no clearing, row 0 never reads it
module dtw_length_normalized_score_core #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dtw_pkg::DIST_W-1:0]    distance_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dtw_pkg::COST_W-1:0]    score_o,
  output logic                          cost_saturated_o,
  input  logic                          cfg_we_i,
  input  logic [dtw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dtw_pkg::CFG_W-1:0]     cfg_data_i
);
  import dtw_pkg::*;

  dtw_cmd_t cmd;
  dtw_sts_t sts;

  dtw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dtw_dp #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .distance_i      (distance_i),
    .score_o         (score_o),
    .cost_saturated_o(cost_saturated_o)
  );

endmodule

@@ design/dtw_ram.sv @@
module dtw_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/dtw_dp.sv @@
module dtw_dp #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dtw_pkg::dtw_cmd_t               cmd_i,
  output dtw_pkg::dtw_sts_t               sts_o,
  input  logic                            cfg_we_i,
  input  logic [dtw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dtw_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic [dtw_pkg::DIST_W-1:0]      distance_i,
  output logic [dtw_pkg::COST_W-1:0]      score_o,
  output logic                            cost_saturated_o
);
  import dtw_pkg::*;

  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
  localparam int RCW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
  localparam int MW  = COST_W + LEN_W;

  logic [CFG_W-1:0]  rows_q, cols_q;
  logic [RCW-1:0]    rows_eff;
  logic [CCW-1:0]    cols_eff;
  logic [RIW-1:0]    row_q;
  logic [CIW-1:0]    col_q;
  logic [DIST_W-1:0] dist_q;
  logic [COST_W-1:0] left_cost_q, diag_cost_q;
  logic [LEN_W-1:0]  left_len_q, diag_len_q;

  logic [MW-1:0]     ram_rdata;
  logic [COST_W-1:0] up_cost, best_cost, cell_cost;
  logic [LEN_W-1:0]  up_len, best_len, cell_len;
  logic [COST_W:0]   sum;
  logic              last_col, last_row;

  logic [COST_W-1:0]    quo_q;
  logic [LEN_W-1:0]     rem_q, div_len_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [LEN_W:0]       trial;
  logic                 trial_ge;
  logic [COST_W-1:0]    score_q;
  logic                 sat_q, div_sat_q;

  // out-of-range counts clamp to 1 .. max
  always_comb begin
    rows_eff = RCW'(rows_q);
    if (rows_q == '0) begin
      rows_eff = RCW'(1);
    end else if (RCW'(rows_q) > RCW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end
    cols_eff = CCW'(cols_q);
    if (cols_q == '0) begin
      cols_eff = CCW'(1);
    end else if (CCW'(cols_q) > CCW'(MAX_COLS)) begin
      cols_eff = CCW'(MAX_COLS);
    end
  end

  assign last_col = (CCW'(col_q) + CCW'(1)) == cols_eff;
  assign last_row = (RCW'(row_q) + RCW'(1)) == rows_eff;

  dtw_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_COLS)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.update),
    .waddr_i(col_q),
    .wdata_i({cell_cost, cell_len}),
    .re_i   (cmd_i.accept),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  // cell evaluation
  always_comb begin
    if (row_q == '0) begin
      up_cost = COST_INF;
      up_len  = LEN_ONE;
    end else begin
      up_cost = ram_rdata[MW-1:LEN_W];
      up_len  = ram_rdata[LEN_W-1:0];
    end
    if (up_cost < left_cost_q && up_cost < diag_cost_q) begin
      best_cost = up_cost;
      best_len  = up_len;
    end else if (diag_cost_q <= left_cost_q && diag_cost_q <= up_cost) begin
      best_cost = diag_cost_q;
      best_len  = diag_len_q;
    end else begin
      best_cost = left_cost_q;
      best_len  = left_len_q;
    end
    sum       = {1'b0, best_cost} + (COST_W + 1)'(dist_q);
    cell_cost = sum[COST_W] ? COST_INF : sum[COST_W-1:0];
    cell_len  = (best_len == LEN_MAX) ? LEN_MAX : best_len + LEN_ONE;
  end

  // restoring divide, one quotient bit per step
  assign trial    = {rem_q, quo_q[COST_W-1]};
  assign trial_ge = trial >= {1'b0, div_len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= CFG_W'(1);
      cols_q      <= CFG_W'(1);
      row_q       <= '0;
      col_q       <= '0;
      left_cost_q <= COST_INF;
      left_len_q  <= LEN_ONE;
      diag_cost_q <= COST_ZERO;
      diag_len_q  <= LEN_ONE;
      cnt_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        default:  ;
      endcase
      row_q       <= '0;
      col_q       <= '0;
      left_cost_q <= COST_INF;
      left_len_q  <= LEN_ONE;
      diag_cost_q <= COST_ZERO;
      diag_len_q  <= LEN_ONE;
    end else begin
      if (cmd_i.update) begin
        if (!last_col) begin
          col_q       <= col_q + CIW'(1);
          left_cost_q <= cell_cost;
          left_len_q  <= cell_len;
          diag_cost_q <= up_cost;
          diag_len_q  <= up_len;
        end else begin
          col_q       <= '0;
          left_cost_q <= COST_INF;
          left_len_q  <= LEN_ONE;
          diag_len_q  <= LEN_ONE;
          if (!last_row) begin
            row_q       <= row_q + RIW'(1);
            diag_cost_q <= COST_INF;
          end else begin
            row_q       <= '0;
            diag_cost_q <= COST_ZERO;
            cnt_q       <= '0;
          end
        end
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dist_q <= distance_i;
    end
    if (cmd_i.update && last_col && last_row) begin
      quo_q     <= cell_cost;
      rem_q     <= '0;
      div_len_q <= cell_len;
      div_sat_q <= cell_cost == COST_INF;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[COST_W-2:0], trial_ge};
      rem_q <= trial_ge ? LEN_W'(trial - {1'b0, div_len_q}) : trial[LEN_W-1:0];
    end
    if (cmd_i.div_step && sts_o.div_last) begin
      score_q <= {quo_q[COST_W-2:0], trial_ge};
      sat_q   <= div_sat_q;
    end
  end

  assign sts_o.matrix_done = last_col && last_row;
  assign sts_o.div_last    = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
  assign score_o           = score_q;
  assign cost_saturated_o  = sat_q;

endmodule

@@ design/dtw_ctrl.sv @@
module dtw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dtw_pkg::dtw_cmd_t cmd_o,
  input  dtw_pkg::dtw_sts_t sts_i
);
  import dtw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CELL,
    S_DIV
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept, step, slot_free;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  // the final step writes the output register, so it needs the slot
  assign slot_free  = !out_valid_q || out_ready_i;
  assign step       = (state_q == S_DIV) && (!sts_i.div_last || slot_free);

  assign cmd_o.accept   = accept;
  assign cmd_o.update   = state_q == S_CELL;
  assign cmd_o.div_step = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_CELL;
          end
        end
        S_CELL: begin
          state_q <= sts_i.matrix_done ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (step && sts_i.div_last) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ tb/sv/dtw_length_normalized_score_core_test.sv @@
`timescale 1ns / 100ps

module dtw_length_normalized_score_core_test;
  import dtw_pkg::*;

  localparam int MAX_COLS        = 1024;
  localparam int MAX_ROWS        = 1024;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 48;
  localparam int ITEMS_PER_STAGE = 220;
  localparam int PRINT_LIMIT     = 200;

  typedef struct packed {
    logic [COST_W-1:0] score;
    logic              saturated;
  } score_t;

  typedef enum int {DIST_ANY, DIST_TIES, DIST_EDGE, DIST_LOW} dist_mix_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [DIST_W-1:0]    distance = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COST_W-1:0]    score;
  logic                 cost_saturated;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [DIST_W-1:0] pending_distances[$];
  score_t            expected_scores[$];
  int unsigned       distances_queued = 0;
  int unsigned       distances_taken = 0;
  int unsigned       send_idle_pct = 15;
  int unsigned       recv_idle_pct = 73;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  bit                in_taken = 1'b0;

  // warping state: previous row plus the west and northwest neighbours
  logic [COST_W-1:0] prev_row_cost [MAX_COLS];
  logic [LEN_W-1:0]  prev_row_len  [MAX_COLS];
  logic [COST_W-1:0] west_cost, nw_cost;
  logic [LEN_W-1:0]  west_len, nw_len;
  int unsigned       at_row, at_col;
  logic [CFG_W-1:0]  rows_reg, cols_reg;

  dtw_length_normalized_score_core #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .distance_i      (distance),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .score_o         (score),
    .cost_saturated_o(cost_saturated),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned active_count(input logic [CFG_W-1:0] value,
                                               input int unsigned limit);
    if (value == '0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  task automatic begin_row(input bit top);
    west_cost = COST_INF;
    west_len  = LEN_ONE;
    nw_cost   = top ? COST_ZERO : COST_INF;
    nw_len    = LEN_ONE;
  endtask

  task automatic restart_matrix();
    at_row = 0;
    at_col = 0;
    begin_row(1'b1);
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    if (idx == CFG_ROWS) begin
      rows_reg = value;
    end else begin
      cols_reg = value;
    end
    restart_matrix();
  endtask

  task automatic predict_cell(input logic [DIST_W-1:0] d);
    logic [COST_W-1:0] north_cost, pick_cost, new_cost;
    logic [LEN_W-1:0]  north_len, pick_len, new_len;
    logic [COST_W:0]   sum;
    int unsigned       n_rows, n_cols;
    score_t            want;
    n_rows = active_count(rows_reg, MAX_ROWS);
    n_cols = active_count(cols_reg, MAX_COLS);
    if (at_row == 0) begin
      north_cost = COST_INF;
      north_len  = LEN_ONE;
    end else begin
      north_cost = prev_row_cost[at_col];
      north_len  = prev_row_len[at_col];
    end
    // north only when strictly cheapest, northwest wins ties, west otherwise
    if (north_cost < west_cost && north_cost < nw_cost) begin
      pick_cost = north_cost;
      pick_len  = north_len;
    end else if (nw_cost <= west_cost && nw_cost <= north_cost) begin
      pick_cost = nw_cost;
      pick_len  = nw_len;
    end else begin
      pick_cost = west_cost;
      pick_len  = west_len;
    end
    sum      = pick_cost + d;
    new_cost = sum[COST_W] ? COST_INF : sum[COST_W-1:0];
    new_len  = (pick_len == LEN_MAX) ? LEN_MAX : pick_len + LEN_ONE;
    prev_row_cost[at_col] = new_cost;
    prev_row_len[at_col]  = new_len;
    nw_cost   = north_cost;
    nw_len    = north_len;
    west_cost = new_cost;
    west_len  = new_len;
    if (at_col + 1 < n_cols) begin
      at_col++;
    end else if (at_row + 1 < n_rows) begin
      at_row++;
      at_col = 0;
      begin_row(1'b0);
    end else begin
      want.score     = new_cost / ((new_len == '0) ? COST_W'(1) : COST_W'(new_len));
      want.saturated = (new_cost == COST_INF);
      expected_scores = {expected_scores, want};
      restart_matrix();
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_score(input logic [COST_W-1:0] got_score, input logic got_sat);
    score_t want;
    if (expected_scores.size() == 0) begin
      report_mismatch($sformatf("score %0h with none outstanding", got_score));
    end else begin
      want = expected_scores.pop_front();
      if (got_score !== want.score)
        report_mismatch($sformatf("score %0h, wanted %0h", got_score, want.score));
      if (got_sat !== want.saturated)
        report_mismatch($sformatf("cost_saturated %b, wanted %b", got_sat, want.saturated));
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    in_taken = in_valid && in_ready;
    if (in_taken) begin
      distances_taken++;
      predict_cell(distance);
    end
    if (out_valid && out_ready) check_score(score, cost_saturated);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL dtw_length_normalized_score_core");
      $finish;
    end
  end

  // sender: hold the item until its transfer, then maybe idle
  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_taken)) begin
    end else if (pending_distances.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      distance <= pending_distances.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic queue_distance(input logic [DIST_W-1:0] d);
    pending_distances = {pending_distances, d};
    distances_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (distances_taken != distances_queued || expected_scores.size() != 0);
  endtask

  // let a partial matrix or the divider finish before the next register write
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] n_rows, input logic [CFG_W-1:0] n_cols);
    write_reg(CFG_ROWS, n_rows);
    write_reg(CFG_COLS, n_cols);
  endtask

  function automatic logic [DIST_W-1:0] rand_distance(input dist_mix_e mix);
    case (mix)
      DIST_TIES: return DIST_W'($urandom_range(0, 2));
      DIST_EDGE: return $urandom_range(1) ? {DIST_W{1'b1}} : {DIST_W{1'b0}};
      DIST_LOW:  return DIST_W'($urandom_range(0, 255));
      default:   return DIST_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 75) return CFG_W'($urandom_range(1, 4));
    if (r < 95) return CFG_W'($urandom_range(5, 10));
    return CFG_W'($urandom_range(11, 24));
  endfunction

  task automatic queue_matrix(input int unsigned cells, input dist_mix_e mix);
    int unsigned pause_at;
    int unsigned i;
    pause_at = ($urandom_range(7) == 0) ? $urandom_range(0, cells - 1) : cells;
    for (i = 0; i < cells; i++) begin
      if (i == pause_at) wait_drained();
      queue_distance(rand_distance(mix));
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] n_rows, input logic [CFG_W-1:0] n_cols,
                           input int unsigned matrices, input bit partial,
                           output int unsigned pushed);
    int unsigned cells;
    int unsigned tail;
    set_size(n_rows, n_cols);
    cells  = active_count(n_rows, MAX_ROWS) * active_count(n_cols, MAX_COLS);
    pushed = 0;
    repeat (matrices) begin
      queue_matrix(cells, dist_mix_e'($urandom_range(0, 3)));
      pushed += cells;
    end
    // broken matrix, cut short by the next register write
    if (partial && cells > 1) begin
      tail = $urandom_range(1, cells - 1);
      repeat (tail) queue_distance(rand_distance(DIST_ANY));
      pushed += tail;
    end
    settle();
  endtask

  initial begin : stimulus
    int unsigned stage;
    int unsigned items;
    int unsigned pushed;
    int unsigned i;
    rows_reg = CFG_W'(1);
    cols_reg = CFG_W'(1);
    restart_matrix();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // 1x1 out of reset
    queue_distance('0);
    queue_distance({DIST_W{1'b1}});
    settle();
    // zero sizes act as one
    set_size('0, '0);
    queue_distance(DIST_W'(16'h8000));
    settle();
    // all ties, with the sender held mid-matrix until everything is back
    set_size(CFG_W'(2), CFG_W'(2));
    repeat (2) queue_distance('0);
    wait_drained();
    repeat (2) queue_distance('0);
    settle();
    set_size(CFG_W'(3), CFG_W'(3));
    for (i = 0; i < 9; i++) queue_distance(DIST_W'(i % 2));
    settle();
    set_size(CFG_W'(2), CFG_W'(3));
    repeat (6) queue_distance({DIST_W{1'b1}});
    settle();
    // a register write restarts an unfinished matrix
    set_size(CFG_W'(3), CFG_W'(2));
    repeat (3) queue_distance(DIST_W'(16'h0101));
    settle();
    set_size(CFG_W'(1), CFG_W'(3));
    queue_distance(DIST_W'(16'h0001));
    queue_distance(DIST_W'(16'h0002));
    queue_distance(DIST_W'(16'h7fff));
    settle();

    for (stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 15 : (stage == 1) ? 73 : 0;
      recv_idle_pct = (stage == 0) ? 73 : (stage == 1) ? 15 : 0;
      if (stage == 2) begin
        // oversized dimensions clamp, cut short by the next register write
        set_size({CFG_W{1'b1}}, {CFG_W{1'b1}});
        repeat (30) queue_distance(rand_distance(DIST_ANY));
        settle();
        // a wide matrix, then a tall one
        set_size(CFG_W'(2), CFG_W'(40));
        queue_matrix(80, DIST_ANY);
        settle();
        set_size(CFG_W'(40), CFG_W'(1));
        queue_matrix(40, DIST_TIES);
        settle();
      end
      items = 0;
      while (items < ITEMS_PER_STAGE) begin
        run_phase(pick_dim(), pick_dim(), $urandom_range(1, 3), ($urandom_range(3) == 0),
                  pushed);
        items += pushed;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS dtw_length_normalized_score_core");
    end else begin
      $display("FAIL dtw_length_normalized_score_core");
    end
    $finish;
  end

endmodule
